FILE: sv/looping_frame_time_lookup_unit_macros.svh
// Assertion helpers for the frame time lookup unit.
`ifndef LOOPING_FRAME_TIME_LOOKUP_UNIT_MACROS_SVH
`define LOOPING_FRAME_TIME_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication.
`define FLT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flt assertion failed");

// Next-cycle implication.
`define FLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flt assertion failed");

`endif

FILE: sv/flt_pkg.sv
`default_nettype none
package flt_pkg;

  localparam int FLT_MAX_FRAMES    = 64;
  localparam int FLT_DURATION_BITS = 24;
  localparam int FLT_TIME_BITS     = 32;

  localparam int IDX_W        = 6;
  localparam int DUR_FIELD_W  = 24;
  localparam int TIME_FIELD_W = 32;
  localparam int TOT_W        = 30;

  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_SETALL = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MOD,
    ST_WALK,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [DUR_FIELD_W-1:0]  duration_value;
    logic [TIME_FIELD_W-1:0] query_time;
    logic [IDX_W-1:0]        frame_select;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]       frame_index;
    logic [DUR_FIELD_W-1:0] frame_duration;
    logic                   no_frames;
    logic                   rejected;
    logic [TOT_W-1:0]       clip_length;
  } out_item_t;

endpackage
`default_nettype wire

FILE: sv/looping_frame_time_lookup_unit.sv
// Append, out-of-range read and empty query: result strobe in the cycle after accept;
// read goes through ST_READ; set-all writes every table entry (one table write per cycle).
// Query with wrap first reduces the time modulo the total (one remainder bit per cycle), then
// walks the frames through the single memory read port; without wrap it walks them directly.
// One item at a time; busy is high until the result strobe. The receiver cannot stall.
// Reset (synchronous, active low) empties the table, zeroes the total, sets looping on.
`default_nettype none
module looping_frame_time_lookup_unit #(
  parameter int MAX_FRAMES    = flt_pkg::FLT_MAX_FRAMES,
  parameter int DURATION_BITS = flt_pkg::FLT_DURATION_BITS,
  parameter int TIME_BITS     = flt_pkg::FLT_TIME_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire flt_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output flt_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata
);

  import flt_pkg::*;

  localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int DUR_W  = (DURATION_BITS < DUR_FIELD_W) ? DURATION_BITS : DUR_FIELD_W;
  localparam int TIME_W = (TIME_BITS < TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;
  localparam int CUM_W  = ((TIME_W > DUR_W) ? TIME_W : DUR_W) + 1;
  localparam int SUM_W  = ((TOT_W > DUR_W) ? TOT_W : DUR_W) + 1;
  localparam int PROD_W = CNT_W + DUR_W;
  localparam int PCMP_W = (PROD_W > TOT_W) ? PROD_W : TOT_W;
  localparam int SCMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic               loop_en_r;
  logic [TIME_W-1:0]  t_r, t_nxt;
  logic [DUR_W-1:0]   dur_r, dur_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [IDX_W-1:0]   sel_r, sel_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [ADDR_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [CUM_W-1:0]   cum_r, cum_nxt;
  logic [ADDR_W-1:0]  fill_idx_r, fill_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               accept;
  logic [DUR_W-1:0]   in_dur;
  logic [TIME_W-1:0]  in_time;
  logic               full;
  logic               in_range;
  logic               wrap;
  logic               issue;
  logic [CUM_W-1:0]   cum_sum;
  logic               walk_done;
  logic               fill_last;
  logic [SUM_W-1:0]   add_sum;
  logic [TOT_W-1:0]   add_sat;
  logic [TOT_W-1:0]   prod_sat;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [DUR_W-1:0]   ram_wdata, ram_rdata;
  logic               mod_start, mod_done;
  logic [TOT_W-1:0]   mod_rem;

  logic               emit;
  logic [IDX_W-1:0]   res_idx;
  logic [DUR_W-1:0]   res_dur;
  logic               res_rej;

  assign busy     = state_r != ST_IDLE;
  assign accept   = start && !busy;
  assign in_dur   = DUR_W'(in_item.duration_value);
  assign in_time  = TIME_W'(in_item.query_time);
  assign full     = count_r >= CNT_W'(MAX_FRAMES);
  assign in_range = SCMP_W'(in_item.frame_select) < SCMP_W'(count_r);
  assign wrap     = loop_en_r && (total_r != '0);
  assign issue    = rd_idx_r < count_r;
  assign cum_sum  = cum_r + CUM_W'(ram_rdata);
  assign walk_done = chk_vld_r &&
                     ((CUM_W'(t_r) < cum_sum) ||
                      (CNT_W'(chk_idx_r) == count_r - CNT_W'(1)));
  assign fill_last = fill_idx_r == ADDR_W'(MAX_FRAMES - 1);
  assign add_sum  = SUM_W'(total_r) + SUM_W'(in_dur);
  assign add_sat  = (add_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOT_W'(add_sum);
  assign prod_sat = (PCMP_W'(prod_r) > PCMP_W'(TOTAL_MAX)) ? TOTAL_MAX : TOT_W'(prod_r);

  flt_ram #(
    .WIDTH (DUR_W),
    .DEPTH (MAX_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  flt_mod #(
    .DIVIDEND_W (TIME_W),
    .DIVISOR_W  (TOT_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_time),
    .divisor  (total_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_item.opcode))
            OP_APPEND: state_nxt = ST_IDLE;
            OP_QUERY: begin
              if (count_r == '0) begin
                state_nxt = ST_IDLE;
              end else begin
                state_nxt = wrap ? ST_MOD : ST_WALK;
              end
            end
            OP_SETALL: state_nxt = ST_FILL;
            OP_READ:   state_nxt = in_range ? ST_READ : ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_MOD: begin
        if (mod_done) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt    = count_r;
    total_nxt    = total_r;
    t_nxt        = t_r;
    dur_nxt      = dur_r;
    prod_nxt     = prod_r;
    sel_nxt      = sel_r;
    rd_idx_nxt   = rd_idx_r;
    chk_vld_nxt  = chk_vld_r;
    chk_idx_nxt  = chk_idx_r;
    cum_nxt      = cum_r;
    fill_idx_nxt = fill_idx_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    mod_start    = 1'b0;
    emit         = 1'b0;
    res_idx      = '0;
    res_dur      = '0;
    res_rej      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_item.opcode))
            OP_APPEND: begin
              emit = 1'b1;
              if (full) begin
                res_rej = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(count_r);
                ram_wdata = in_dur;
                count_nxt = count_r + CNT_W'(1);
                total_nxt = add_sat;
                res_idx   = IDX_W'(count_r);
                res_dur   = in_dur;
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                emit = 1'b1;
              end else begin
                t_nxt       = in_time;
                rd_idx_nxt  = '0;
                chk_vld_nxt = 1'b0;
                cum_nxt     = '0;
                mod_start   = wrap;
              end
            end
            OP_SETALL: begin
              dur_nxt      = in_dur;
              prod_nxt     = PROD_W'(count_r) * PROD_W'(in_dur);
              fill_idx_nxt = '0;
            end
            OP_READ: begin
              sel_nxt = in_item.frame_select;
              if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(in_item.frame_select);
              end else begin
                emit    = 1'b1;
                res_idx = in_item.frame_select;
                res_rej = 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        emit    = 1'b1;
        res_idx = sel_r;
        res_dur = ram_rdata;
      end
      ST_MOD: begin
        if (mod_done) begin
          t_nxt = TIME_W'(mod_rem);
        end
      end
      ST_WALK: begin
        chk_vld_nxt = issue;
        chk_idx_nxt = ADDR_W'(rd_idx_r);
        if (issue) begin
          ram_re     = 1'b1;
          ram_raddr  = ADDR_W'(rd_idx_r);
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (chk_vld_r) begin
          cum_nxt = cum_sum;
        end
        if (walk_done) begin
          emit    = 1'b1;
          res_idx = IDX_W'(chk_idx_r);
          res_dur = ram_rdata;
        end
      end
      ST_FILL: begin
        ram_we       = 1'b1;
        ram_waddr    = fill_idx_r;
        ram_wdata    = dur_r;
        fill_idx_nxt = fill_idx_r + ADDR_W'(1);
        if (fill_last) begin
          total_nxt = prod_sat;
          emit      = 1'b1;
          res_dur   = dur_r;
        end
      end
      default: ;
    endcase

    out_valid_nxt               = emit;
    out_item_nxt.frame_index    = res_idx;
    out_item_nxt.frame_duration = DUR_FIELD_W'(res_dur);
    out_item_nxt.no_frames      = count_nxt == '0;
    out_item_nxt.rejected       = res_rej;
    out_item_nxt.clip_length    = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      loop_en_r   <= 1'b1;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        loop_en_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    dur_r      <= dur_nxt;
    prod_r     <= prod_nxt;
    sel_r      <= sel_nxt;
    rd_idx_r   <= rd_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    cum_r      <= cum_nxt;
    fill_idx_r <= fill_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

FILE: sv/flt_ram.sv
`default_nettype none
module flt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: sv/flt_mod.sv
`default_nettype none
module flt_mod #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 30
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic      [DIVISOR_W-1:0]  rem
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] dq_r, dq_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    dsor;
  logic                  active;

  assign active = cnt_r != '0;
  assign trial  = {rem_r, dq_r[DIVIDEND_W-1]};
  assign dsor   = {1'b0, divisor};

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = CNT_W'(DIVIDEND_W);
      rem_nxt = '0;
      dq_nxt  = dividend;
    end else if (active) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      dq_nxt   = {dq_r[DIVIDEND_W-2:0], 1'b0};
      done_nxt = cnt_r == CNT_W'(1);
      if (trial >= dsor) begin
        rem_nxt = DIVISOR_W'(trial - dsor);
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

FILE: sv/flt_checker.sv
`default_nettype none
`include "looping_frame_time_lookup_unit_macros.svh"
module flt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire flt_pkg::out_item_t out_item,
  input wire logic               out_valid
);

  import flt_pkg::*;

  `FLT_ASSERT_NEXT(a_accept_resp, clk, rst_n, start && !busy, busy || out_valid)
  `FLT_ASSERT_SAME(a_result_cause, clk, rst_n, out_valid, $past(busy) || $past(start))
  `FLT_ASSERT_SAME(a_busy_ends_result, clk, rst_n, $fell(busy), out_valid)
  `FLT_ASSERT_SAME(a_reject_no_dur, clk, rst_n, out_valid && out_item.rejected,
                   out_item.frame_duration == '0)
  `FLT_ASSERT_SAME(a_empty_no_length, clk, rst_n, out_valid && out_item.no_frames,
                   out_item.clip_length == '0)

endmodule

bind looping_frame_time_lookup_unit flt_checker u_flt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_item  (out_item),
  .out_valid (out_valid)
);
`default_nettype wire
